>>> sv/ioq_pkg.sv
// ----------------------------------------------------------------------------
// ioq_pkg: shared constants and types for the interval overlap query block
// Table geometry, field widths, command and status codes.
// ----------------------------------------------------------------------------
package ioq_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BADSPAN = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] start;
        logic [KEY_W-1:0] stop;
        logic [VAL_W-1:0] value;
    } t_entry;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             ins;    // insert strobe
        logic             rot;    // rotate chain by one
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        logic [VAL_W-1:0] v;
    } t_cell_ctl;
endpackage

>>> sv/ioq_cell.sv
// ----------------------------------------------------------------------------
// ioq_cell: one slot of the sorted interval chain
// Holds one entry. On insert, decides keep / take left neighbor / take new.
// On rotate, takes right neighbor (used by the query scan).
// ----------------------------------------------------------------------------
module ioq_cell (
    input  logic                i_clk,
    input  ioq_pkg::t_cell_ctl  i_ctl,
    input  logic                i_valid,       // this slot is occupied
    input  logic                i_left_valid,
    input  logic                i_left_goes,   // left neighbor sorts at/before new
    input  ioq_pkg::t_entry     i_left,
    input  ioq_pkg::t_entry     i_right,
    output ioq_pkg::t_entry     o_entry,
    output logic                o_goes         // this entry stays before new one
);
    import ioq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry = r_entry;
    assign o_goes  = i_valid && ((r_entry.start < i_ctl.a) ||
                     ((r_entry.start == i_ctl.a) && (r_entry.stop <= i_ctl.b)));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.rot) begin
            n_entry = i_right;
        end else if (i_ctl.ins && !o_goes) begin
            if (i_left_valid && !i_left_goes) begin
                n_entry = i_left;
            end else begin
                n_entry.start = i_ctl.a;
                n_entry.stop  = i_ctl.b;
                n_entry.value = i_ctl.v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule

>>> sv/interval_overlap_query_top.sv
// ----------------------------------------------------------------------------
// interval_overlap_query_top: sorted interval table with overlap search
// Clear, insert and overlap query over a chain of entry cells.
// ----------------------------------------------------------------------------
// The table is a chain of TABLE_DEPTH cells kept sorted by (start, stop).
// Clear and insert each return an ack item that is registered and shows up the
// cycle after acceptance; with the consumer keeping up, one such item can be
// taken every cycle. Insert compares every cell against the new key in parallel
// and shifts right in one step. A query rotates the whole chain once, one cell
// per cycle while the output register can take each new hit, examining the
// entry in cell 0 (the head), which holds table index 0, 1, 2 and so on in
// turn. The query holds the input through the accept, TABLE_DEPTH rotate steps
// and the final item, and longer while a new hit or the final item finds the
// output register still full. The rotation length is set by the chain depth,
// not by the entry count, so every entry returns to its slot. Hits come out in
// table order; the result item holding the last hit (or the single empty
// result) has last set. An output register holds each result item until taken.
// ----------------------------------------------------------------------------
module interval_overlap_query_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: command[1:0], start_req[32:2], stop[63:33],
    // value[95:64]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: hit_start[30:0], hit_stop[61:31], hit_value[93:62],
    // status[95:94]
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    output logic         m_axis_tuser   // found
);
    import ioq_pkg::*;

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_FLUSH } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [KEY_W-1:0] r_longest;
    logic [IDX_W-1:0] r_step;     // rotation step in a query
    logic [CNT_W-1:0] r_pos;      // table index of chain head
    logic             r_done;     // stop reached: keep rotating, emit nothing
    logic [KEY_W-1:0] r_qa;
    logic [KEY_W-1:0] r_qb;
    logic [KEY_W-1:0] r_key;
    logic             r_pend;     // a hit is held back to learn if it is last
    t_entry           r_pend_e;

    logic             r_ovalid;
    t_entry           r_oent;
    logic             r_ofound;
    logic             r_olast;
    logic [1:0]       r_ostat;

    t_cell_ctl        w_ctl;
    t_entry           w_ent  [TABLE_DEPTH];
    logic             w_goes [TABLE_DEPTH];
    logic             w_val  [TABLE_DEPTH];

    t_cmd             w_cmd;
    logic [KEY_W-1:0] w_a;
    logic [KEY_W-1:0] w_b;
    logic [VAL_W-1:0] w_v;
    logic             w_acc;
    logic             w_out_free;
    logic             w_ins_ok;
    logic [1:0]       w_ins_stat;
    logic [KEY_W-1:0] w_len;
    t_entry           w_head;
    logic             w_in_rng;
    logic             w_hit;
    logic             w_stop_here;
    logic             w_emit_ok;
    logic             w_oload;    // output register takes a new item

    assign w_cmd = t_cmd'(s_axis_tdata[1:0]);
    assign w_a   = s_axis_tdata[32:2];
    assign w_b   = s_axis_tdata[63:33];
    assign w_v   = s_axis_tdata[95:64];

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_ins_ok      = (w_b > w_a) && (r_count < CNT_W'(TABLE_DEPTH));
    assign w_ins_stat    = (w_b <= w_a) ? ST_BADSPAN : (w_ins_ok ? ST_OK : ST_FULL);
    assign w_len         = w_b - w_a;

    // head of the chain is cell 0; rotation shifts every entry one cell left
    // and feeds cell 0 back into the last cell
    assign w_head      = w_ent[0];
    assign w_in_rng    = (r_pos < r_count) && (w_head.start >= r_key);
    assign w_stop_here = w_in_rng && (w_head.start >= r_qb);
    assign w_hit       = w_in_rng && !w_stop_here && !r_done && (w_head.stop > r_qa);
    // a new hit needs the output register free when one is already pending
    assign w_emit_ok   = !(w_hit && r_pend) || w_out_free;

    assign w_oload = (w_acc && ((w_cmd == CMD_CLEAR) || (w_cmd == CMD_INSERT)))
                  || ((r_state == S_SCAN) && w_emit_ok && w_hit && r_pend)
                  || ((r_state == S_FLUSH) && w_out_free);

    always_comb begin
        w_ctl.a   = w_a;
        w_ctl.b   = w_b;
        w_ctl.v   = w_v;
        w_ctl.ins = w_acc && (w_cmd == CMD_INSERT) && w_ins_ok;
        w_ctl.rot = (r_state == S_SCAN) && w_emit_ok;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_val[g] = CNT_W'(g) < r_count;
        if (g == 0) begin : g_first
            ioq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_valid     (w_val[g]),
                .i_left_valid(1'b0),
                .i_left_goes (1'b0),
                .i_left      ('0),
                .i_right     (w_ent[(g + 1) % TABLE_DEPTH]),
                .o_entry     (w_ent[g]),
                .o_goes      (w_goes[g])
            );
        end else begin : g_rest
            ioq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_valid     (w_val[g]),
                .i_left_valid(w_val[g-1]),
                .i_left_goes (w_goes[g-1]),
                .i_left      (w_ent[g-1]),
                .i_right     (w_ent[(g + 1) % TABLE_DEPTH]),
                .o_entry     (w_ent[g]),
                .o_goes      (w_goes[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_longest <= '0;
            r_ovalid  <= 1'b0;
            r_pend    <= 1'b0;
            r_step    <= '0;
        end else begin
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_oent   <= '0;
                        r_ofound <= 1'b0;
                        r_olast  <= 1'b1;
                        r_ostat  <= (w_cmd == CMD_INSERT) ? w_ins_stat : ST_OK;
                        case (w_cmd)
                            CMD_CLEAR: begin
                                r_count   <= '0;
                                r_longest <= '0;
                            end
                            CMD_INSERT: begin
                                if (w_ins_ok) begin
                                    r_count <= r_count + 1'b1;
                                    if (w_len > r_longest) r_longest <= w_len;
                                end
                            end
                            CMD_QUERY: begin
                                r_state <= S_SCAN;
                                r_step  <= '0;
                                // head cell holds table index 0 before rotating
                                r_pos   <= '0;
                                r_done  <= 1'b0;
                                r_pend  <= 1'b0;
                                r_qa    <= w_a;
                                r_qb    <= w_b;
                                r_key   <= (w_a > r_longest) ? w_a - r_longest : '0;
                            end
                            default: begin
                                // unknown command: no result, no state change
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_emit_ok) begin
                        if (w_stop_here) r_done <= 1'b1;
                        if (w_hit) begin
                            r_pend   <= 1'b1;
                            r_pend_e <= w_head;
                            if (r_pend) begin
                                r_oent   <= r_pend_e;
                                r_ofound <= 1'b1;
                                r_olast  <= 1'b0;
                                r_ostat  <= ST_OK;
                            end
                        end
                        // head after rotation holds the next table index
                        r_pos  <= r_pos + 1'b1;
                        r_step <= r_step + 1'b1;
                        if (r_step == IDX_W'(TABLE_DEPTH - 1)) r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_oent   <= r_pend ? r_pend_e : '0;
                        r_ofound <= r_pend;
                        r_olast  <= 1'b1;
                        r_ostat  <= ST_OK;
                        r_pend   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ostat, r_oent.value, r_oent.stop, r_oent.start};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ofound;

    // a query scan never changes the table size
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("count changed during scan");
    // count never exceeds depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("count overflow");
    // a result without a hit always ends its item
    a_nohit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_ofound) |-> r_olast)
        else $error("empty result not last");
    // no input accepted while a query is running
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");
endmodule

>>> tb/tb_interval_overlap_query_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_overlap_query_top: self-checking bench for the interval table
// Drives clear, insert and overlap query items with random gaps and output
// stalls, predicts every result item from a local sorted table, and compares
// each field of every result taken from the output stream.
// ----------------------------------------------------------------------------
module tb_interval_overlap_query_top;
    import ioq_pkg::*;

    // one expected result item
    typedef struct {
        logic [KEY_W-1:0] hit_start;
        logic [KEY_W-1:0] hit_stop;
        logic [VAL_W-1:0] hit_value;
        logic             found;
        logic             last;
        logic [1:0]       status;
    } t_hit;

    // directed stimulus row; chk set when the single result is typed in
    typedef struct {
        t_cmd             cmd;
        logic [KEY_W-1:0] a;
        logic [KEY_W-1:0] b;
        logic [VAL_W-1:0] v;
        bit               chk;
        logic [1:0]       status;
    } t_row;

    localparam logic [KEY_W-1:0] KMAX = {KEY_W{1'b1}};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata from bit 0: command, start_req, stop, value
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata from bit 0: hit_start, hit_stop, hit_value, status
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;  // found

    // predictor state: sorted copy of the table
    logic [KEY_W-1:0] tbl_start [TABLE_DEPTH];
    logic [KEY_W-1:0] tbl_stop  [TABLE_DEPTH];
    logic [VAL_W-1:0] tbl_value [TABLE_DEPTH];
    int               tbl_count;
    logic [KEY_W-1:0] tbl_longest;

    t_hit pending_hits[$];
    int   n_errors = 0;
    bit   rx_busy_free = 1'b0;  // stall-free stretch on the output side
    bit   tx_gap_free = 1'b0;

    t_row rows[$];

    always #5 i_clk = ~i_clk;

    interval_overlap_query_top dut (.*);

    function automatic t_hit mk_ack(logic [1:0] st);
        t_hit h;
        h.hit_start = '0; h.hit_stop = '0; h.hit_value = '0;
        h.found = 1'b0; h.last = 1'b1; h.status = st;
        return h;
    endfunction

    // append one expected result item
    function automatic void queue_hit(t_hit h);
        pending_hits.insert(pending_hits.size(), h);
    endfunction

    // apply one item to the local table and queue its expected results
    task automatic predict_table_op(t_cmd cmd, logic [KEY_W-1:0] a,
                                    logic [KEY_W-1:0] b, logic [VAL_W-1:0] v);
        int   pos;
        int   n;
        t_hit h;
        logic [KEY_W-1:0] key;
        case (cmd)
            CMD_CLEAR: begin
                tbl_count = 0;
                tbl_longest = '0;
                queue_hit(mk_ack(ST_OK));
            end
            CMD_INSERT: begin
                if (b <= a) begin
                    queue_hit(mk_ack(ST_BADSPAN));
                end else if (tbl_count >= TABLE_DEPTH) begin
                    queue_hit(mk_ack(ST_FULL));
                end else begin
                    pos = 0;
                    while (pos < tbl_count && (tbl_start[pos] < a ||
                           (tbl_start[pos] == a && tbl_stop[pos] <= b)))
                        pos++;
                    for (int i = tbl_count; i > pos; i--) begin
                        tbl_start[i] = tbl_start[i-1];
                        tbl_stop[i]  = tbl_stop[i-1];
                        tbl_value[i] = tbl_value[i-1];
                    end
                    tbl_start[pos] = a;
                    tbl_stop[pos]  = b;
                    tbl_value[pos] = v;
                    tbl_count++;
                    if (b - a > tbl_longest) tbl_longest = b - a;
                    queue_hit(mk_ack(ST_OK));
                end
            end
            CMD_QUERY: begin
                // scan from the first start not below qstart - longest
                key = (a > tbl_longest) ? a - tbl_longest : '0;
                n = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_start[i] < key) continue;
                    if (tbl_start[i] >= b) break;
                    if (tbl_stop[i] > a) begin
                        h.hit_start = tbl_start[i];
                        h.hit_stop  = tbl_stop[i];
                        h.hit_value = tbl_value[i];
                        h.found = 1'b1; h.last = 1'b0; h.status = ST_OK;
                        queue_hit(h);
                        n++;
                    end
                end
                if (n == 0) queue_hit(mk_ack(ST_OK));
                else pending_hits[$].last = 1'b1;
            end
            default: ;  // unknown command: ignored
        endcase
    endtask

    // send one item; returns at the falling edge after it is accepted,
    // with tvalid still high (the next send changes or lowers it, drain lowers it)
    task automatic send_item(t_cmd cmd, logic [KEY_W-1:0] a,
                             logic [KEY_W-1:0] b, logic [VAL_W-1:0] v);
        while (!tx_gap_free && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, b, a, cmd};
        predict_table_op(cmd, a, b, v);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(negedge i_clk);
    endtask

    // output side: random stalls, compare at the rising edge
    always @(negedge i_clk) begin
        m_axis_tready <= rx_busy_free || ($urandom_range(99) >= 27);
    end

    always @(posedge i_clk) begin
        t_hit e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected result item: data %h", m_axis_tdata);
                n_errors++;
            end else begin
                e = pending_hits.pop_front();
                if (m_axis_tdata[30:0] !== e.hit_start) begin
                    $error("hit_start exp %h got %h", e.hit_start, m_axis_tdata[30:0]);
                    n_errors++;
                end
                if (m_axis_tdata[61:31] !== e.hit_stop) begin
                    $error("hit_stop exp %h got %h", e.hit_stop, m_axis_tdata[61:31]);
                    n_errors++;
                end
                if (m_axis_tdata[93:62] !== e.hit_value) begin
                    $error("hit_value exp %h got %h", e.hit_value, m_axis_tdata[93:62]);
                    n_errors++;
                end
                if (m_axis_tdata[95:94] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_axis_tdata[95:94]);
                    n_errors++;
                end
                if (m_axis_tuser !== e.found) begin
                    $error("found exp %0d got %0d", e.found, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    function automatic void add_row(t_cmd c, logic [KEY_W-1:0] a, logic [KEY_W-1:0] b,
                                    logic [VAL_W-1:0] v, bit chk, logic [1:0] st);
        t_row r;
        r.cmd = c; r.a = a; r.b = b; r.v = v; r.chk = chk; r.status = st;
        rows.insert(rows.size(), r);
    endfunction

    // random interval biased toward a small window so queries get hits
    task automatic rand_span(output logic [KEY_W-1:0] a, output logic [KEY_W-1:0] b);
        case ($urandom_range(9))
            0: begin a = KEY_W'($urandom()); b = KEY_W'($urandom()); end
            1: begin a = KEY_W'($urandom_range(20)); b = a; end
            2: begin
                a = KMAX - KEY_W'($urandom_range(30));
                b = KMAX - KEY_W'($urandom_range(30));
            end
            default: begin
                a = KEY_W'($urandom_range(1000));
                b = a + KEY_W'($urandom_range(($urandom_range(3) == 0) ? 600 : 60));
            end
        endcase
    endtask

    initial begin
        logic [KEY_W-1:0] a, b;
        t_cmd             c;
        int               k;
        tbl_count = 0;
        tbl_longest = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        add_row(CMD_QUERY,  0, KMAX, 32'h0, 1, ST_OK);       // empty table
        add_row(CMD_INSERT, 5, 5, 32'h1, 1, ST_BADSPAN);    // stop == start
        add_row(CMD_INSERT, 9, 3, 32'h1, 1, ST_BADSPAN);    // stop < start
        add_row(CMD_INSERT, 0, KMAX, 32'h8000_0000, 1, ST_OK);
        add_row(CMD_INSERT, 10, 20, 32'h7fff_ffff, 1, ST_OK);
        add_row(CMD_INSERT, 10, 20, 32'hffff_ffff, 1, ST_OK); // equal keys
        add_row(CMD_INSERT, 10, 15, 32'h1234_5678, 1, ST_OK);
        add_row(CMD_INSERT, KMAX - 1, KMAX, 32'h5555_aaaa, 1, ST_OK);
        add_row(CMD_QUERY,  12, 13, 32'h0, 0, ST_OK);
        add_row(CMD_QUERY,  13, 12, 32'h0, 0, ST_OK);        // inverted query
        add_row(CMD_QUERY,  KMAX, KMAX, 32'h0, 0, ST_OK);
        add_row(CMD_QUERY,  0, 0, 32'h0, 0, ST_OK);
        add_row(CMD_NONE,   1, 2, 32'h3, 0, ST_OK);          // ignored
        add_row(CMD_CLEAR,  KMAX, KMAX, 32'hffff_ffff, 1, ST_OK);
        add_row(CMD_QUERY,  0, KMAX, 32'h0, 1, ST_OK);
        foreach (rows[i]) begin
            send_item(rows[i].cmd, rows[i].a, rows[i].b, rows[i].v);
            if (rows[i].chk && rows[i].cmd != CMD_NONE) begin
                // typed-in single result must agree with the predictor too
                if (pending_hits[$].status !== rows[i].status ||
                    pending_hits[$].found !== 1'b0 || pending_hits[$].last !== 1'b1) begin
                    $error("status exp %0d got %0d (table row %0d)",
                           rows[i].status, pending_hits[$].status, i);
                    n_errors++;
                end
            end
        end

        // fill the table to overflow
        for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
            rand_span(a, b);
            if (b <= a) b = a + KEY_W'(1 + $urandom_range(50));
            send_item(CMD_INSERT, a, b, $urandom());
        end
        send_item(CMD_INSERT, 1, 0, 32'h0);   // bad span beats full
        send_item(CMD_QUERY, 0, KMAX, 32'h0); // every entry hits
        drain();                              // sender waits for all results
        send_item(CMD_CLEAR, 0, 0, 32'h0);

        // random part: mostly inserts and queries, clears now and then
        for (int n = 0; n < 370; n++) begin
            if (n == 150) begin tx_gap_free = 1'b1; rx_busy_free = 1'b1; end
            if (n == 230) begin tx_gap_free = 1'b0; rx_busy_free = 1'b0; end
            k = $urandom_range(99);
            c = (k < 4) ? CMD_CLEAR : (k < 6) ? CMD_NONE : (k < 52) ? CMD_INSERT
                : CMD_QUERY;
            rand_span(a, b);
            send_item(c, a, b, $urandom());
        end

        drain();
        repeat (TABLE_DEPTH + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
